/* sv/vofn_pkg.sv */
// Shared types and constants for the VOF interface-normal block.
// No dependencies; the front, the queue, the back end and the top level use it.
package vofn_pkg;

  localparam int FRAC_BITS_DEF = 15;
  localparam int FRAC_W        = 16;
  localparam int SIZE_W        = 16;
  localparam int OUT_W         = 16;
  localparam int SUM_W         = 21;
  localparam int MAG_W         = 20;
  localparam int IDX_W         = 5;
  localparam int SAMPLES       = 27;
  localparam int CENTRE_IDX    = 13;

  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = 1;
  localparam int Q_CNT_W       = 2;

  localparam int MUL_A_W       = 32;
  localparam int MUL_B_W       = 30;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int QMAG_W        = 52;
  localparam int NORM_W        = 30;
  localparam int ROOT_W        = 32;
  localparam int RAD_W         = 64;

  // One neighbourhood ready for normalisation
  typedef struct packed {
    logic                     active;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic signed [SUM_W-1:0]  sum_z;
    logic [SIZE_W-1:0]        size_x;
    logic [SIZE_W-1:0]        size_y;
    logic [SIZE_W-1:0]        size_z;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_NORM,
    BK_SQ,
    BK_SQRT,
    BK_DIV,
    BK_HOLD
  } bk_state_t;

endpackage

/* sv/vofn_front.sv */
// Front end: takes samples, builds the three weighted difference sums, classifies the cell.
// Depends on vofn_pkg.
module vofn_front import vofn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FRAC_W-1:0] in_fraction,
  input  logic              in_present,
  input  logic              in_last,
  input  logic [SIZE_W-1:0] in_cell_size_x,
  input  logic [SIZE_W-1:0] in_cell_size_y,
  input  logic [SIZE_W-1:0] in_cell_size_z,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FRAC_W-1:0] cfg_interface_epsilon,
  input  q_status_t         q_status,
  output logic              push,
  output job_t              push_job
);

  localparam int CW = (FRAC_BITS >= 16) ? FRAC_BITS + 1 : 17;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic [1:0]              cx_r, cy_r, cz_r;
  logic [FRAC_W-1:0]       centre_r, centre_nxt;
  logic [FRAC_W-1:0]       eps_r;
  logic                    accept, in_range;
  logic [FRAC_W-1:0]       v;
  logic signed [SUM_W-1:0] tx, ty, tz;
  logic [CW-1:0]           c_ext, gap;
  logic                    flat, edge_c;

  assign in_stall  = q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_status.full;
  assign push      = accept && in_last;
  assign in_range  = idx_r < IDX_W'(SAMPLES);
  assign v         = in_present ? in_fraction : '0;

  always_comb begin
    tx = SUM_W'(v) <<< ((cy_r == 2'd1 ? 1 : 0) + (cz_r == 2'd1 ? 1 : 0));
    ty = SUM_W'(v) <<< ((cx_r == 2'd1 ? 1 : 0) + (cz_r == 2'd1 ? 1 : 0));
    tz = SUM_W'(v) <<< ((cx_r == 2'd1 ? 1 : 0) + (cy_r == 2'd1 ? 1 : 0));
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    sum_z_nxt  = sum_z_r;
    centre_nxt = centre_r;
    if (in_range) begin
      if (cx_r == 2'd0) sum_x_nxt = sum_x_r - tx;
      else if (cx_r == 2'd2) sum_x_nxt = sum_x_r + tx;
      if (cy_r == 2'd0) sum_y_nxt = sum_y_r - ty;
      else if (cy_r == 2'd2) sum_y_nxt = sum_y_r + ty;
      if (cz_r == 2'd0) sum_z_nxt = sum_z_r - tz;
      else if (cz_r == 2'd2) sum_z_nxt = sum_z_r + tz;
      if (idx_r == IDX_W'(CENTRE_IDX)) centre_nxt = v;
    end
    c_ext  = CW'(centre_nxt);
    gap    = (c_ext > ONE) ? c_ext - ONE : ONE - c_ext;
    flat   = (sum_x_nxt == '0) && (sum_y_nxt == '0) && (sum_z_nxt == '0);
    edge_c = (c_ext < CW'(eps_r)) || (gap < CW'(eps_r));
    push_job.active = !flat && !edge_c;
    push_job.sum_x  = sum_x_nxt;
    push_job.sum_y  = sum_y_nxt;
    push_job.sum_z  = sum_z_nxt;
    push_job.size_x = (in_cell_size_x == '0) ? SIZE_W'(1) : in_cell_size_x;
    push_job.size_y = (in_cell_size_y == '0) ? SIZE_W'(1) : in_cell_size_y;
    push_job.size_z = (in_cell_size_z == '0) ? SIZE_W'(1) : in_cell_size_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= FRAC_W'(1);
    end else if (cfg_valid) begin
      eps_r <= cfg_interface_epsilon;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_z_r  <= '0;
      centre_r <= '0;
      idx_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
    end else if (accept) begin
      if (in_last) begin
        sum_x_r  <= '0;
        sum_y_r  <= '0;
        sum_z_r  <= '0;
        centre_r <= '0;
        idx_r    <= '0;
        cx_r     <= '0;
        cy_r     <= '0;
        cz_r     <= '0;
      end else begin
        sum_x_r  <= sum_x_nxt;
        sum_y_r  <= sum_y_nxt;
        sum_z_r  <= sum_z_nxt;
        centre_r <= centre_nxt;
        if (in_range) begin
          idx_r <= idx_r + IDX_W'(1);
          if (cx_r != 2'd2) begin
            cx_r <= cx_r + 2'd1;
          end else begin
            cx_r <= '0;
            if (cy_r != 2'd2) begin
              cy_r <= cy_r + 2'd1;
            end else begin
              cy_r <= '0;
              cz_r <= cz_r + 2'd1;
            end
          end
        end
      end
    end
  end

endmodule

/* sv/vofn_queue.sv */
// Two-entry queue of finished neighbourhoods between the front and the back end.
// Depends on vofn_pkg.
module vofn_queue import vofn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t status
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign status.full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign status.empty = cnt_r == '0;
  assign pop_job      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + Q_PTR_W'(1);
      if (pop)  rd_r <= rd_r + Q_PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* sv/vofn_back.sv */
// Back end: scales the sums by cell sizes, normalises, takes the root and divides.
// One shared multiplier, a bit-serial square root and a restoring divider; depends on vofn_pkg.
module vofn_back import vofn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  q_status_t               q_status,
  input  job_t                    q_job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_normal_x,
  output logic signed [OUT_W-1:0] out_normal_y,
  output logic signed [OUT_W-1:0] out_normal_z,
  output logic                    out_interface_res
);

  localparam int QB  = FRAC_BITS + 2;
  localparam int NW  = NORM_W + FRAC_BITS + 1;
  localparam int DCW = $clog2(QB + 1);
  localparam int SW  = (QB + 1 > 17) ? QB + 1 : 17;
  localparam logic [SW-1:0] HI_V   = (FRAC_BITS >= 15) ? SW'(32767) : (SW'(1) << FRAC_BITS) - 1'b1;
  localparam logic [SW-1:0] LO_MAG = (FRAC_BITS >= 15) ? SW'(32768) : SW'(1) << FRAC_BITS;

  bk_state_t state_r, state_nxt;

  job_t                     job_r;
  logic [2:0]               k_r;
  logic [MUL_A_W-1:0]       hprod_r [3];
  logic [QMAG_W-1:0]        mag_r [3];
  logic [QMAG_W-1:0]        mx_r;
  logic [PROD_W-1:0]        sq_r;
  logic [RAD_W-1:0]         rad_r, res_r, bit_r;
  logic [ROOT_W-1:0]        root_r, rem_r;
  logic [QB-1:0]            low_r, quo_r;
  logic [DCW-1:0]           dcnt_r;
  logic signed [OUT_W-1:0]  nrm_r [3];
  logic                     intf_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_x_r, out_y_r, out_z_r;
  logic                     out_intf_r;

  logic [MUL_A_W-1:0]       op_a;
  logic [MUL_B_W-1:0]       op_b;
  logic [PROD_W-1:0]        prod;
  logic signed [SUM_W-1:0]  sums [3];
  logic [MAG_W-1:0]         dmag [3];
  logic [1:0]               j;
  logic [RAD_W-1:0]         trial_root;
  logic                     root_ge;
  logic [NW-1:0]            num;
  logic [ROOT_W:0]          trial_div;
  logic                     div_ge;
  logic [QB-1:0]            quo_nxt;
  logic [SW-1:0]            qe, sat;
  logic                     out_free, last_step;

  assign out_valid         = out_valid_r;
  assign out_normal_x      = out_x_r;
  assign out_normal_y      = out_y_r;
  assign out_normal_z      = out_z_r;
  assign out_interface_res = out_intf_r;
  assign out_free          = !out_valid_r || !out_stall;

  always_comb begin
    sums[0] = job_r.sum_x;
    sums[1] = job_r.sum_y;
    sums[2] = job_r.sum_z;
    for (int i = 0; i < 3; i++) begin
      dmag[i] = sums[i][SUM_W-1] ? MAG_W'(-sums[i]) : sums[i][MAG_W-1:0];
    end
    j = 2'(k_r - 3'd3);
  end

  // Shared multiplier: size products, then scaled sums, then squares
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == BK_MUL) begin
      case (k_r)
        3'd0: begin
          op_a = MUL_A_W'(job_r.size_y);
          op_b = MUL_B_W'(job_r.size_z);
        end
        3'd1: begin
          op_a = MUL_A_W'(job_r.size_x);
          op_b = MUL_B_W'(job_r.size_z);
        end
        3'd2: begin
          op_a = MUL_A_W'(job_r.size_x);
          op_b = MUL_B_W'(job_r.size_y);
        end
        default: begin
          op_a = hprod_r[j];
          op_b = MUL_B_W'(dmag[j]);
        end
      endcase
    end else if (state_r == BK_SQ) begin
      op_a = MUL_A_W'(mag_r[k_r[1:0]][NORM_W-1:0]);
      op_b = mag_r[k_r[1:0]][NORM_W-1:0];
    end
  end
  assign prod = op_a * op_b;

  always_comb begin
    trial_root = res_r + bit_r;
    root_ge    = rad_r >= trial_root;
    num        = {1'b0, mag_r[k_r[1:0]][NORM_W-1:0], FRAC_BITS'(0)} + NW'(root_r >> 1);
    trial_div  = {rem_r, low_r[QB-1]};
    div_ge     = trial_div >= {1'b0, root_r};
    quo_nxt    = {quo_r[QB-2:0], div_ge};
    qe         = SW'(quo_nxt);
    if (sums[k_r[1:0]][SUM_W-1]) begin
      sat = (qe > LO_MAG) ? -LO_MAG : -qe;
    end else begin
      sat = (qe > HI_V) ? HI_V : qe;
    end
    last_step = dcnt_r == DCW'(QB);
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          state_nxt = q_job.active ? BK_MUL : BK_HOLD;
        end
      end
      BK_MUL:  if (k_r == 3'd5) state_nxt = BK_NORM;
      BK_NORM: begin
        if (mx_r[QMAG_W-1:30] == '0 && mx_r[29]) state_nxt = BK_SQ;
      end
      BK_SQ:   if (k_r == 3'd2) state_nxt = BK_SQRT;
      BK_SQRT: if (bit_r == RAD_W'(1)) state_nxt = BK_DIV;
      BK_DIV:  if (dcnt_r == DCW'(QB) && k_r == 3'd2) state_nxt = BK_HOLD;
      BK_HOLD: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        job_r <= q_job;
        k_r   <= '0;
        mx_r  <= '0;
        for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
        intf_r <= 1'b0;
      end
      BK_MUL: begin
        k_r <= k_r + 3'd1;
        if (k_r < 3'd3) begin
          hprod_r[k_r[1:0]] <= prod[MUL_A_W-1:0];
        end else begin
          mag_r[j] <= prod[QMAG_W-1:0];
          if (prod[QMAG_W-1:0] > mx_r) mx_r <= prod[QMAG_W-1:0];
        end
      end
      BK_NORM: begin
        k_r  <= '0;
        sq_r <= '0;
        if (mx_r[QMAG_W-1:30] != '0) begin
          mx_r <= mx_r >> 1;
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (!mx_r[29]) begin
          mx_r <= mx_r << 1;
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end
      end
      BK_SQ: begin
        k_r   <= k_r + 3'd1;
        sq_r  <= sq_r + prod;
        rad_r <= RAD_W'(sq_r + prod);
        res_r <= '0;
        bit_r <= RAD_W'(1) << 62;
      end
      BK_SQRT: begin
        if (root_ge) begin
          rad_r <= rad_r - trial_root;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        k_r    <= '0;
        dcnt_r <= '0;
        if (bit_r == RAD_W'(1)) begin
          root_r <= root_ge ? ROOT_W'((res_r >> 1) + bit_r) : ROOT_W'(res_r >> 1);
        end
      end
      BK_DIV: begin
        if (dcnt_r == '0) begin
          rem_r  <= ROOT_W'(num[NW-1:QB]);
          low_r  <= num[QB-1:0];
          quo_r  <= '0;
          dcnt_r <= DCW'(1);
        end else begin
          rem_r <= div_ge ? ROOT_W'(trial_div - {1'b0, root_r}) : trial_div[ROOT_W-1:0];
          low_r <= low_r << 1;
          quo_r <= quo_nxt;
          if (last_step) begin
            nrm_r[k_r[1:0]] <= sat[OUT_W-1:0];
            dcnt_r          <= '0;
            k_r             <= k_r + 3'd1;
            intf_r          <= 1'b1;
          end else begin
            dcnt_r <= dcnt_r + DCW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: load from HOLD once the last result has gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == BK_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_HOLD && out_free) begin
      out_x_r    <= nrm_r[0];
      out_y_r    <= nrm_r[1];
      out_z_r    <= nrm_r[2];
      out_intf_r <= intf_r;
    end
  end

endmodule

/* sv/vof_interface_normal_3d.sv */
// Top level of the VOF interface-normal block: front end, queue, back end.
// Depends on vofn_pkg, vofn_front, vofn_queue and vofn_back.
//
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | fraction, present, last, cell sizes
//  out_    | out       | out_valid/out_stall| normal x/y/z, interface_res
//  cfg_    | in        | cfg_valid/cfg_ready| interface_epsilon
//
// Samples are taken one per cycle while the two-entry queue has room; an item
// that does not close a neighbourhood never waits on the back end otherwise.
// The back end takes a neighbourhood with an interface through six multiplier
// passes, up to 29 one-bit normalising shifts, three squares, 32 square-root
// steps and three restoring divisions; one without goes from IDLE straight
// to HOLD.
// Reset is synchronous and active low; it clears the sums, the queue and the
// back-end sequencer, and sets the epsilon to one LSB. A stalled result holds
// in the output register while the back end may take the next neighbourhood.
module vof_interface_normal_3d import vofn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [FRAC_W-1:0]       in_fraction,
  input  logic                    in_present,
  input  logic                    in_last,
  input  logic [SIZE_W-1:0]       in_cell_size_x,
  input  logic [SIZE_W-1:0]       in_cell_size_y,
  input  logic [SIZE_W-1:0]       in_cell_size_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_normal_x,
  output logic signed [OUT_W-1:0] out_normal_y,
  output logic signed [OUT_W-1:0] out_normal_z,
  output logic                    out_interface_res,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [FRAC_W-1:0]       cfg_interface_epsilon
);

  q_status_t q_status;
  logic      push, pop;
  job_t      push_job, pop_job;

  // Accumulate samples and classify the centre cell
  vofn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_fraction           (in_fraction),
    .in_present            (in_present),
    .in_last               (in_last),
    .in_cell_size_x        (in_cell_size_x),
    .in_cell_size_y        (in_cell_size_y),
    .in_cell_size_z        (in_cell_size_z),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_interface_epsilon (cfg_interface_epsilon),
    .q_status              (q_status),
    .push                  (push),
    .push_job              (push_job)
  );

  // Decouple the sample stream from the normalisation
  vofn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // Scale, normalise, root and divide
  vofn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .q_job             (pop_job),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_normal_x      (out_normal_x),
    .out_normal_y      (out_normal_y),
    .out_normal_z      (out_normal_z),
    .out_interface_res (out_interface_res)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue underflow");

  // No interface means a zero normal
  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_interface_res) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("normal not zero without interface");

endmodule
